### src/cobs_frame_decoder_with_checksum_assert.svh
// ----------------------------------------------------------------------------
// COBS decoder assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef COBS_FRAME_DECODER_WITH_CHECKSUM_ASSERT_SVH
`define COBS_FRAME_DECODER_WITH_CHECKSUM_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define COBS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define COBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/cobs_pkg.sv
// ----------------------------------------------------------------------------
// COBS decoder package
// Types, status codes and constants shared by the decoder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cobs_pkg;

  localparam int MaxFrameDefault = 256;
  localparam int MinFrameBytes   = 4;
  localparam int FrameOverhead   = 3;
  localparam int CodePosW        = 9;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CHECKSUM = 2'd1,
    ST_SHORT    = 2'd2,
    ST_OVERRUN  = 2'd3
  } status_t;

  typedef struct packed {
    logic       is_frame_end;
    logic [7:0] data_byte;
    status_t    status;
    logic [7:0] payload_length;
  } result_t;

endpackage

### src/cobs_frame_decoder_with_checksum.sv
// ----------------------------------------------------------------------------
// COBS frame decoder with checksum
// Strips COBS framing from received bytes and judges each frame at its zero
// delimiter.
// ----------------------------------------------------------------------------
// Line bytes enter on the rx_byte channel (in_valid, in_ready). Each accepted
// beat gives zero or one result beat on the output channel (out_valid,
// out_ready): a decoded data byte with is_frame_end low, or at a delimiter a
// frame-end beat with status and payload_length. Data bytes leave one byte
// late, so the checksum byte of a frame is never passed on.
// A beat is taken into an input register, decoded by the frame logic once the
// result register is free, and written to the result register, which offers
// the result to the receiver.
// One beat per cycle is sustained while out_ready stays high; the limit is the
// single decode step between the two registers.
// Reset clears the frame state and both registers; the next byte starts a
// new frame. When the receiver stalls, the result register holds its beat,
// the input register fills, and in_ready drops until out_ready returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cobs_frame_decoder_with_checksum #(
  parameter int MAX_FRAME = cobs_pkg::MaxFrameDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       is_frame_end,
  output logic [7:0] data_byte,
  output logic [1:0] status,
  output logic [7:0] payload_length
);
  import cobs_pkg::*;

  logic       held;
  logic [7:0] held_data;
  logic       free;
  logic       take;
  logic       res_valid;
  result_t    res;
  result_t    res_q;

  assign take = held && free;

  cobs_in_reg u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .take      (take),
    .held      (held),
    .held_data (held_data)
  );

  cobs_core #(
    .MAX_FRAME (MAX_FRAME)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .byte_in   (held_data),
    .res_valid (res_valid),
    .res       (res)
  );

  cobs_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (take && res_valid),
    .res       (res),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_q     (res_q)
  );

  assign is_frame_end   = res_q.is_frame_end;
  assign data_byte      = res_q.data_byte;
  assign status         = res_q.status;
  assign payload_length = res_q.payload_length;

`include "cobs_frame_decoder_with_checksum_assert.svh"

  `COBS_ASSERT_NOW(a_stall_cause, !in_ready, held && out_valid && !out_ready, "input stalled without a blocked result")
  `COBS_ASSERT_NOW(a_len_only_ok, out_valid && (status != ST_OK || !is_frame_end), payload_length == 8'd0, "length set on a non-ok beat")
  `COBS_ASSERT_NEXT(a_delim_result, take && held_data == 8'd0, out_valid && is_frame_end, "delimiter gave no frame-end beat")

endmodule

### src/cobs_in_reg.sv
// ----------------------------------------------------------------------------
// COBS decoder input register
// Holds one received beat until the decode stage takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cobs_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       take,
  output logic       held,
  output logic [7:0] held_data
);
  import cobs_pkg::*;

  logic valid_q;
  logic [7:0] data_q;

  assign in_ready  = !valid_q || take;
  assign held      = valid_q;
  assign held_data = data_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_q <= 1'b1;
    end else if (take) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_q <= rx_byte;
    end
  end

endmodule

### src/cobs_core.sv
// ----------------------------------------------------------------------------
// COBS decoder core
// Frame state and the per-beat decode, checksum and frame-end judgment.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cobs_core #(
  parameter int MAX_FRAME = cobs_pkg::MaxFrameDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic [7:0]       byte_in,
  output logic             res_valid,
  output cobs_pkg::result_t res
);
  import cobs_pkg::*;

  localparam int PosW = $clog2(MAX_FRAME);

  logic [PosW-1:0]     frame_position, frame_position_next;
  logic [CodePosW-1:0] next_code_position, next_code_position_next;
  logic [7:0]          running_sum, running_sum_next;
  logic [7:0]          held_byte, held_byte_next;
  logic                held_valid, held_valid_next;
  logic                overrun_flag, overrun_flag_next;

  logic [CodePosW-1:0] pos_ext;
  logic [7:0]          pos8;
  logic [7:0]          decoded;
  logic                at_code;

  assign pos_ext = CodePosW'(frame_position);
  assign pos8    = 8'(frame_position);
  assign at_code = (pos_ext == next_code_position);
  assign decoded = at_code ? 8'd0 : byte_in;

  always_comb begin
    frame_position_next     = frame_position;
    next_code_position_next = next_code_position;
    running_sum_next        = running_sum;
    held_byte_next          = held_byte;
    held_valid_next         = held_valid;
    overrun_flag_next       = overrun_flag;
    res_valid               = 1'b0;
    res                     = '0;
    res.status              = ST_OK;

    if (byte_in == 8'd0) begin
      res_valid        = 1'b1;
      res.is_frame_end = 1'b1;
      if (overrun_flag) begin
        res.status = ST_OVERRUN;
      end else if (32'(frame_position) + 32'd1 < 32'(MinFrameBytes)) begin
        res.status = ST_SHORT;
      end else if (running_sum != 8'd0) begin
        res.status = ST_CHECKSUM;
      end else begin
        res.status         = ST_OK;
        res.payload_length = pos8 + 8'd1 - 8'(FrameOverhead);
      end
      frame_position_next     = '0;
      next_code_position_next = '0;
      running_sum_next        = '0;
      held_byte_next          = '0;
      held_valid_next         = 1'b0;
      overrun_flag_next       = 1'b0;
    end else if (overrun_flag || (32'(frame_position) >= MAX_FRAME - 1)) begin
      overrun_flag_next = 1'b1;
    end else begin
      if (at_code) begin
        next_code_position_next = pos_ext + CodePosW'(byte_in);
      end
      if (frame_position != '0) begin
        if (held_valid) begin
          res_valid     = 1'b1;
          res.data_byte = held_byte;
        end
        held_byte_next   = decoded;
        held_valid_next  = 1'b1;
        running_sum_next = running_sum + decoded;
      end
      frame_position_next = frame_position + PosW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position     <= '0;
      next_code_position <= '0;
      running_sum        <= '0;
      held_byte          <= '0;
      held_valid         <= 1'b0;
      overrun_flag       <= 1'b0;
    end else if (take) begin
      frame_position     <= frame_position_next;
      next_code_position <= next_code_position_next;
      running_sum        <= running_sum_next;
      held_byte          <= held_byte_next;
      held_valid         <= held_valid_next;
      overrun_flag       <= overrun_flag_next;
    end
  end

endmodule

### src/cobs_out_reg.sv
// ----------------------------------------------------------------------------
// COBS decoder result register
// Holds one result beat for the receiver and reports when it can take more.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cobs_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  cobs_pkg::result_t res,
  output logic              free,
  output logic              out_valid,
  input  logic              out_ready,
  output cobs_pkg::result_t res_q
);
  import cobs_pkg::*;

  logic valid_q;

  assign free      = !valid_q || out_ready;
  assign out_valid = valid_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (out_ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_q <= res;
    end
  end

endmodule
